>>> rtl/rlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlc_pkg;

    localparam int NUM_CH     = 3;
    localparam int LEVEL_W    = 8;
    localparam int PROD_W     = 16;
    localparam int TRANS_W    = 16;
    localparam int MS_W       = 17;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam logic [MS_W-1:0]    MS_MAX    = 17'd131071;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // opcode values carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    typedef logic [1:0] t_chan;
    localparam t_chan CH_FIRST = 2'd0;
    localparam t_chan CH_LAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MUL,
        ST_TGT,
        ST_DIV,
        ST_STW,
        ST_FIN,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  tick;
        logic  mul;
        logic  tgt;
        logic  div_step;
        logic  stw;
        logic  fin;
        logic  out_load;
        t_chan chan;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic opcode;
        logic immediate;
        logic tick_emit;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/rlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rlc_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  rlc_pkg::t_stat i_stat,
    output rlc_pkg::t_cmd  o_cmd
);

    rlc_pkg::t_state r_state, n_state;
    rlc_pkg::t_chan  r_chan, n_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlc_pkg::ST_IDLE;
            r_chan  <= rlc_pkg::CH_FIRST;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        unique case (r_state)
            rlc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_chan  = rlc_pkg::CH_FIRST;
                    n_state = rlc_pkg::ST_MUL;
                end
            end
            rlc_pkg::ST_TICK: begin
                n_state = i_stat.tick_emit ? rlc_pkg::ST_EMIT : rlc_pkg::ST_IDLE;
            end
            rlc_pkg::ST_MUL: begin
                n_state = rlc_pkg::ST_TGT;
            end
            rlc_pkg::ST_TGT: begin
                if (i_stat.need_div) begin
                    n_state = rlc_pkg::ST_DIV;
                end else if (r_chan == rlc_pkg::CH_LAST) begin
                    n_state = rlc_pkg::ST_FIN;
                end else begin
                    n_chan  = r_chan + 2'd1;
                    n_state = rlc_pkg::ST_MUL;
                end
            end
            rlc_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = rlc_pkg::ST_STW;
                end
            end
            rlc_pkg::ST_STW: begin
                if (r_chan == rlc_pkg::CH_LAST) begin
                    n_state = rlc_pkg::ST_FIN;
                end else begin
                    n_chan  = r_chan + 2'd1;
                    n_state = rlc_pkg::ST_MUL;
                end
            end
            rlc_pkg::ST_FIN: begin
                n_state = i_stat.immediate ? rlc_pkg::ST_EMIT : rlc_pkg::ST_IDLE;
            end
            rlc_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = rlc_pkg::ST_IDLE;
                end
            end
            default: n_state = rlc_pkg::ST_IDLE;
        endcase
        // a tick skips the colour sequence
        if (r_state == rlc_pkg::ST_IDLE && i_in_valid && i_stat.opcode == rlc_pkg::OP_TICK) begin
            n_state = rlc_pkg::ST_TICK;
        end
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        o_in_ready = 1'b0;
        unique case (r_state)
            rlc_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            rlc_pkg::ST_TICK: o_cmd.tick     = 1'b1;
            rlc_pkg::ST_MUL:  o_cmd.mul      = 1'b1;
            rlc_pkg::ST_TGT:  o_cmd.tgt      = 1'b1;
            rlc_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            rlc_pkg::ST_STW:  o_cmd.stw      = 1'b1;
            rlc_pkg::ST_FIN:  o_cmd.fin      = 1'b1;
            rlc_pkg::ST_EMIT: o_cmd.out_load = i_stat.out_free;
            default: o_cmd.out_load = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rlc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rlc_datapath #(
    parameter int FADE_STEPS = 1020
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [rlc_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire [rlc_pkg::IN_USER_W-1:0]     i_in_user,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic [rlc_pkg::OUT_DATA_W-1:0]   o_out_data,
    input  rlc_pkg::t_cmd                    i_cmd,
    output rlc_pkg::t_stat                   o_stat
);

    localparam int QW  = $clog2(FADE_STEPS + 1);
    localparam int IW  = $clog2(FADE_STEPS + 2);
    localparam int DCW = $clog2(QW);
    localparam int LW  = rlc_pkg::LEVEL_W;
    localparam int MW  = rlc_pkg::MS_W;

    // latched item
    logic                       r_op;
    logic [LW-1:0]              r_comp [rlc_pkg::NUM_CH];
    logic [LW-1:0]              r_bright;
    logic                       r_on;
    logic [rlc_pkg::TRANS_W-1:0] r_tr;

    // fade state
    logic [LW-1:0]              r_cur  [rlc_pkg::NUM_CH];
    logic [QW-1:0]              r_mag  [rlc_pkg::NUM_CH];
    logic                       r_neg  [rlc_pkg::NUM_CH];
    logic [QW-1:0]              r_cnt  [rlc_pkg::NUM_CH];
    logic [IW-1:0]              r_idx;
    logic [rlc_pkg::MS_W-1:0]   r_ms;
    logic                       r_fade;

    // shared arithmetic
    logic [rlc_pkg::PROD_W-1:0] r_prod;
    logic [LW-1:0]              r_rem;
    logic [LW-1:0]              r_dvs;
    logic [QW-1:0]              r_dnd;
    logic [QW-1:0]              r_quo;
    logic [DCW-1:0]             r_dcnt;
    logic                       r_dneg;

    // output register
    logic                          r_ovalid;
    logic [rlc_pkg::OUT_DATA_W-1:0] r_odata;

    logic [rlc_pkg::PROD_W:0]  w_qsum;
    logic [LW-1:0]             w_tgt_new;
    logic [LW-1:0]             w_cur_sel;
    logic [LW:0]               w_diff;
    logic [LW:0]               w_diff_neg;
    logic [LW-1:0]             w_absd;
    logic                      w_imm;
    logic [LW:0]               w_trial;
    logic                      w_ge;
    logic [rlc_pkg::MS_W-1:0]  w_ms_next;
    logic                      w_qual;
    logic                      w_do_step;
    logic [LW-1:0]             w_cur_adv [rlc_pkg::NUM_CH];
    logic [QW-1:0]             w_cnt_adv [rlc_pkg::NUM_CH];

    assign w_imm = (r_tr == '0);

    // x / 255 for x up to 255 * 255, the largest product
    assign w_qsum    = {1'b0, r_prod} + {9'd0, r_prod[rlc_pkg::PROD_W-1:8]} + 17'd1;
    assign w_tgt_new = w_qsum[15:8];

    assign w_cur_sel  = r_cur[i_cmd.chan];
    assign w_diff     = {1'b0, w_tgt_new} - {1'b0, w_cur_sel};
    assign w_diff_neg = '0 - w_diff;
    assign w_absd     = w_diff[LW] ? w_diff_neg[LW-1:0] : w_diff[LW-1:0];

    // one restoring division bit
    assign w_trial = {r_rem, r_dnd[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    assign w_ms_next = (r_ms == rlc_pkg::MS_MAX) ? r_ms : r_ms + MW'(1);
    assign w_qual    = r_fade && (w_ms_next > {1'b0, r_tr});
    assign w_do_step = w_qual && !(r_idx > IW'(FADE_STEPS));

    // per-channel fade step, counter tracks index modulo step
    always_comb begin
        logic [QW:0] cnt_inc;
        for (int c = 0; c < rlc_pkg::NUM_CH; c++) begin
            cnt_inc      = {1'b0, r_cnt[c]} + {{QW{1'b0}}, 1'b1};
            w_cur_adv[c] = r_cur[c];
            w_cnt_adv[c] = r_cnt[c];
            if (r_mag[c] != '0) begin
                if (r_cnt[c] == '0) begin
                    if (r_neg[c]) begin
                        w_cur_adv[c] = (r_cur[c] == '0) ? r_cur[c] : r_cur[c] - LW'(1);
                    end else begin
                        w_cur_adv[c] = (r_cur[c] == rlc_pkg::LEVEL_MAX) ? r_cur[c]
                                                                        : r_cur[c] + LW'(1);
                    end
                end
                w_cnt_adv[c] = (cnt_inc == {1'b0, r_mag[c]}) ? '0 : cnt_inc[QW-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr     <= '0;
            r_idx    <= '0;
            r_ms     <= '0;
            r_fade   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < rlc_pkg::NUM_CH; c++) begin
                r_cur[c] <= '0;
                r_mag[c] <= '0;
                r_neg[c] <= 1'b0;
                r_cnt[c] <= '0;
            end
        end else begin
            if (i_cmd.latch && i_in_user[0] == rlc_pkg::OP_CMD) begin
                r_tr <= i_in_data[48:33];
            end
            if (i_cmd.tick) begin
                r_ms <= w_do_step ? '0 : w_ms_next;
                if (w_qual && !w_do_step) begin
                    r_fade <= 1'b0;
                end
                if (w_do_step) begin
                    r_idx <= r_idx + IW'(1);
                    for (int c = 0; c < rlc_pkg::NUM_CH; c++) begin
                        r_cur[c] <= w_cur_adv[c];
                        r_cnt[c] <= w_cnt_adv[c];
                    end
                end
            end
            if (i_cmd.tgt) begin
                if (w_imm) begin
                    r_cur[i_cmd.chan] <= w_tgt_new;
                end else begin
                    r_mag[i_cmd.chan] <= '0;
                    r_cnt[i_cmd.chan] <= '0;
                end
            end
            if (i_cmd.stw) begin
                r_mag[i_cmd.chan] <= r_quo;
                r_neg[i_cmd.chan] <= r_dneg;
                r_cnt[i_cmd.chan] <= '0;
            end
            if (i_cmd.fin) begin
                r_fade <= !w_imm;
                if (!w_imm) begin
                    r_idx <= '0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_in_user[0];
            r_comp[0] <= i_in_data[7:0];
            r_comp[1] <= i_in_data[15:8];
            r_comp[2] <= i_in_data[23:16];
            r_bright <= i_in_data[31:24];
            r_on     <= i_in_data[32];
        end
        if (i_cmd.mul) begin
            r_prod <= r_on ? {8'd0, r_comp[i_cmd.chan]} * {8'd0, r_bright} : '0;
        end
        if (i_cmd.tgt) begin
            r_rem  <= '0;
            r_dvs  <= w_absd;
            r_dnd  <= QW'(FADE_STEPS);
            r_quo  <= '0;
            r_dcnt <= DCW'(QW - 1);
            r_dneg <= w_diff[LW];
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? LW'(w_trial - {1'b0, r_dvs}) : w_trial[LW-1:0];
            r_quo  <= {r_quo[QW-2:0], w_ge};
            r_dnd  <= {r_dnd[QW-2:0], 1'b0};
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.out_load) begin
            r_odata <= {7'd0, r_fade, ~r_cur[2], ~r_cur[1], ~r_cur[0]};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // the opcode is looked at on the accept edge, before the latch
    assign o_stat.opcode    = i_cmd.latch ? i_in_user[0] : r_op;
    assign o_stat.immediate = w_imm;
    assign o_stat.tick_emit = w_do_step;
    assign o_stat.need_div  = !w_imm && (w_diff != '0);
    assign o_stat.div_last  = (r_dcnt == '0);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

endmodule

`default_nettype wire

>>> rtl/rgb_led_crossfader_core.sv
// results: a tick yields one only when it makes a fade step, an immediate colour command always,
// both held back while the output register still holds an unaccepted result
// fading colour command: busy through the channel steps and the step divider, no result
// throughput: one item at a time; a fading command also divides per channel
// (bit-serial step divider shared by the channels)
// reset: synchronous active-low i_rst_n clears levels, steps, counters, output valid
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_crossfader_core #(
    parameter int FADE_STEPS = 1020
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // slave side, one transfer per tick or colour command
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // cmd_red[7:0], cmd_green[15:8], cmd_blue[23:16], cmd_brightness[31:24],
    // cmd_on[32], cmd_transition_ms[48:33], zero fill to 56
    input  wire [55:0] s_axis_tdata,
    // opcode[0]: tick or colour command
    input  wire [0:0]  s_axis_tuser,
    // master side, one transfer per result
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // pwm_red[7:0], pwm_green[15:8], pwm_blue[23:16], fading[24], zero fill to 32
    output logic [31:0] m_axis_tdata
);

    rlc_pkg::t_cmd  w_cmd;
    rlc_pkg::t_stat w_stat;

    // sequencer: walks the three channels through multiply, scale and divide
    rlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // levels, steps, shared multiplier and divider, output register
    rlc_datapath #(
        .FADE_STEPS (FADE_STEPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

`ifndef SYNTH
    // a result is never loaded over one that still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded while output still pending");

    // only one datapath operation per cycle
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.latch, w_cmd.tick, w_cmd.mul, w_cmd.tgt,
                  w_cmd.div_step, w_cmd.stw, w_cmd.fin, w_cmd.out_load}))
        else $error("conflicting datapath operations");

    // an accepted item is worked on before the next one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous item in progress");

    // a load always makes the output valid
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("output not valid after load");
`endif

endmodule

`default_nettype wire
